>>> src/fpbw_pkg.sv
// Package for the frame buffer pixel blend writer.
// Status codes and shared field widths; no dependencies.
`timescale 1ns / 1ps

package fpbw_pkg;

    localparam int COORD_W = 12;
    localparam int CH_W    = 8;
    localparam int IDX_W   = 22;
    localparam int ADDR_W  = 19;
    localparam int PIX_W   = 32;
    localparam int STAT_W  = 2;

    localparam logic [STAT_W-1:0] ST_OPAQUE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_BLENDED = 2'd1;
    localparam logic [STAT_W-1:0] ST_CLIPPED = 2'd2;
    localparam logic [STAT_W-1:0] ST_SKIPPED = 2'd3;

    localparam logic [CH_W-1:0] ALPHA_ZERO = 8'h00;
    localparam logic [CH_W-1:0] ALPHA_FULL = 8'hFF;

endpackage

>>> src/framebuffer_pixel_blend_writer.sv
// Channel | Dir | Handshake                    | Payload
// s_axis  | in  | s_axis_tvalid/s_axis_tready  | tuser: func; tdata: pos_x, pos_y, pixel_color
// m_axis  | out | m_axis_tvalid/m_axis_tready  | tuser: status; tdata: write_address, written_value
// One transaction in processing. Clipped, skipped, opaque and full-alpha blend writes pass
// from the address state to the done state; a partial-alpha blend adds a read-modify-write
// on the frame store (address, read, mix, divide, write back). The result sits in
// an output register, so input is taken again while it waits; the block stalls only if a
// second result is ready before the first is taken. Synchronous reset; no store clearing,
// entries are undefined until written. Depends on fpbw_pkg, fpbw_ram, fpbw_blend.
`timescale 1ns / 1ps

module framebuffer_pixel_blend_writer #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [0:0]  s_axis_tuser,   // [0] func
    input  logic [55:0] s_axis_tdata,   // [11:0] pos_x, [23:12] pos_y, [55:24] pixel_color
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic [55:0] m_axis_tdata    // [18:0] write_address, [50:19] written_value, zeros
);
    import fpbw_pkg::*;

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int DIM_W = COORD_W - 1;
    localparam logic [DIM_W-1:0] WIDTH_C  = DIM_W'(SCREEN_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_C = DIM_W'(SCREEN_HEIGHT);

    typedef enum logic [2:0] {
        S_IDLE, S_ADDR, S_READ, S_MIX, S_DIV, S_DONE
    } t_state;

    t_state               r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    logic                 r_func;
    logic [COORD_W-1:0]   r_px, r_py;
    logic [PIX_W-1:0]     r_color;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [STAT_W-1:0]    r_status, n_status;
    logic [PIX_W-1:0]     r_wval, n_wval;
    logic                 r_wr, n_wr;
    logic [STAT_W-1:0]    r_out_status;
    logic [ADDR_W-1:0]    r_out_addr;
    logic [PIX_W-1:0]     r_out_value;

    logic                 in_fire, out_load, clip;
    logic [IDX_W-1:0]     idx;
    logic [PIX_W-1:0]     bg, blend_value;
    logic [CH_W-1:0]      alpha;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign alpha    = r_color[PIX_W-1 -: CH_W];

    assign clip = r_px[COORD_W-1] || r_py[COORD_W-1]
               || (r_px[DIM_W-1:0] >= WIDTH_C) || (r_py[DIM_W-1:0] >= HEIGHT_C);
    assign idx  = IDX_W'(r_py[DIM_W-1:0]) * IDX_W'(WIDTH_C) + IDX_W'(r_px[DIM_W-1:0]);

    fpbw_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (out_load && r_wr),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (r_wval),
        .i_re    (r_state == S_READ),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (bg)
    );

    fpbw_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (r_state == S_MIX),
        .i_alpha (alpha),
        .i_fg    (r_color[3*CH_W-1:0]),
        .i_bg    (bg[3*CH_W-1:0]),
        .o_value (blend_value)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_idx       = r_idx;
        n_status    = r_status;
        n_wval      = r_wval;
        n_wr        = r_wr;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_idx   = idx;
                n_state = S_DONE;
                priority if (clip) begin
                    n_status = ST_CLIPPED;
                    n_wval   = '0;
                    n_wr     = 1'b0;
                end else if (!r_func) begin
                    n_status = ST_OPAQUE;
                    n_wval   = r_color;
                    n_wr     = 1'b1;
                end else if (alpha == ALPHA_ZERO) begin
                    n_status = ST_SKIPPED;
                    n_wval   = '0;
                    n_wr     = 1'b0;
                end else begin
                    n_status = ST_BLENDED;
                    n_wval   = r_color;
                    n_wr     = 1'b1;
                    if (alpha != ALPHA_FULL) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_MIX;
            S_MIX:  n_state = S_DIV;
            S_DIV: begin
                n_wval  = blend_value;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (in_fire) begin
            r_func  <= s_axis_tuser[0];
            r_px    <= s_axis_tdata[11:0];
            r_py    <= s_axis_tdata[23:12];
            r_color <= s_axis_tdata[55:24];
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_wval   <= n_wval;
        r_wr     <= n_wr;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_addr   <= r_wr ? r_idx[ADDR_W-1:0] : '0;
            r_out_value  <= r_wval;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {5'b0, r_out_value, r_out_addr};

endmodule

>>> src/fpbw_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fpbw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/fpbw_blend.sv
// Source-over channel mixer: registered weighted sums, then divide by 255.
// Depends on fpbw_pkg.
`timescale 1ns / 1ps

module fpbw_blend (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [fpbw_pkg::CH_W-1:0]       i_alpha,
    input  logic [3*fpbw_pkg::CH_W-1:0]     i_fg,
    input  logic [3*fpbw_pkg::CH_W-1:0]     i_bg,
    output logic [fpbw_pkg::PIX_W-1:0]      o_value
);
    import fpbw_pkg::*;

    localparam int SUM_W = 2 * CH_W;
    // ceil(2^23 / 255); exact for sums below 2^16
    localparam logic [SUM_W-1:0] RECIP_255 = 16'd32897;
    localparam int RECIP_SH = 23;

    logic [SUM_W-1:0]   r_sum [3];
    logic [SUM_W-1:0]   n_sum [3];
    logic [CH_W-1:0]    inv_alpha;
    logic [2*SUM_W-1:0] prod  [3];
    logic [CH_W-1:0]    quot  [3];

    assign inv_alpha = ALPHA_FULL - i_alpha;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = SUM_W'(i_alpha) * SUM_W'(i_fg[c*CH_W +: CH_W])
                     + SUM_W'(inv_alpha) * SUM_W'(i_bg[c*CH_W +: CH_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = {{SUM_W{1'b0}}, r_sum[c]} * {{SUM_W{1'b0}}, RECIP_255};
            quot[c] = prod[c][RECIP_SH +: CH_W];
        end
    end

    assign o_value = {ALPHA_ZERO, quot[2], quot[1], quot[0]};

endmodule

>>> src/fpbw_checker.sv
// Port-level checks for the frame buffer pixel blend writer, bound to the top level.
// Depends on fpbw_pkg and framebuffer_pixel_blend_writer.
`timescale 1ns / 1ps

module fpbw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser,
    input logic [55:0] m_axis_tdata
);
    import fpbw_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken while one is in flight");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_CLIPPED || m_axis_tuser == ST_SKIPPED)
            |-> m_axis_tdata == '0)
        else $error("clipped or skipped pixel reports an address or value");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind framebuffer_pixel_blend_writer fpbw_checker u_fpbw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);
